### rtl/core/vplfc_pkg.sv
// ----------------------------------------------------------------------------
// vplfc_pkg
// Shared widths, codes and control types of the vsync period lock frame clock.
// ----------------------------------------------------------------------------
package vplfc_pkg;

	// Field and state widths
	localparam int TIME_W   = 32;                 // millisecond counter
	localparam int FRAC_W   = 8;                  // fraction bits of fixed point values
	localparam int PER_W    = 24;                 // locked period
	localparam int ANIM_W   = 48;                 // animation clock
	localparam int CNT_W    = 17;                 // run counter
	localparam int BOUND_W  = 10;                 // interval bounds
	localparam int REQ_W    = 16;                 // required count
	localparam int FUNC_W   = 2;

	// Shared divider: dividend is a time scaled by the fraction bits
	localparam int DIVD_W   = TIME_W + FRAC_W;
	localparam int DIVR_W   = PER_W;
	localparam int DCNT_W   = $clog2(DIVD_W + 1);

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Stream payloads
	localparam int IN_DATA_W   = TIME_W;
	localparam int OUT_FIELD_W = 1 + PER_W + ANIM_W + ANIM_W;
	localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

	// Register reset values
	localparam logic [BOUND_W-1:0] LOWER_RST = BOUND_W'(15);
	localparam logic [BOUND_W-1:0] UPPER_RST = BOUND_W'(18);
	localparam logic [REQ_W-1:0]   REQ_RST   = REQ_W'(100);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOWER_BOUND = 2'd0,
		REG_UPPER_BOUND = 2'd1,
		REG_REQ_COUNT   = 2'd2,
		REG_UNUSED      = 2'd3
	} vplfc_reg_t;

	// Event kinds
	typedef enum logic [FUNC_W-1:0] {
		FUNC_SWAP    = 2'd0,
		FUNC_ADVANCE = 2'd1,
		FUNC_START   = 2'd2,
		FUNC_NONE    = 2'd3
	} vplfc_func_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_OUT
	} vplfc_state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;     // latch the input transfer
		logic div_start;  // launch the shared divider
		logic commit;     // update the clock state
		logic load_out;   // load the output register
	} vplfc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_div;   // this event needs a quotient
		logic div_done;   // divider result ready
		logic out_free;   // output register can take a result
	} vplfc_sts_t;

endpackage

### rtl/core/vsync_period_lock_frame_clock.sv
// ----------------------------------------------------------------------------
// vsync_period_lock_frame_clock
// Frame clock that locks onto a stable display swap period.
// ----------------------------------------------------------------------------
// Events (swap, advance, start) carry a free-running millisecond count and
// are handled one at a time; each gives exactly one result. An event goes
// from input transfer through evaluation to a loaded result, and through a
// divide when a quotient is needed (a swap that latches a new period, or an
// advance that snaps forward to the next period multiple): the shared
// restoring divider produces one of its 40 quotient bits per cycle. A new
// event is taken the cycle after its predecessor's result is loaded, so no
// event is taken before the last one is through. That result may still wait
// in the output register; a following event then holds in its last step
// until the result side takes it. Times and periods are fixed point with 8
// fraction bits. Registers may be written whenever the block is idle.
// ----------------------------------------------------------------------------
module vsync_period_lock_frame_clock (
	input  logic                              clk,
	input  logic                              arst_n,
	// Events
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [vplfc_pkg::IN_DATA_W-1:0]   s_tdata,   // [31:0] now_ms
	input  logic [vplfc_pkg::FUNC_W-1:0]      s_tuser,   // [1:0] func
	// Results
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [vplfc_pkg::OUT_DATA_W-1:0]  m_tdata,   // [0] period_found,
	                                                     // [24:1] stable_period,
	                                                     // [72:25] animation_time,
	                                                     // [120:73] reported_time
	// Register writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [vplfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vplfc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import vplfc_pkg::*;

	vplfc_cmd_t cmd;
	vplfc_sts_t sts;

	assign cfg_ready = 1'b1;

	vplfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vplfc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// One event in flight: no transfer in the cycle after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an event is in flight");

	// A finished quotient is always consumed by a state update
	a_div_commit: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> cmd.commit)
		else $error("divider result not committed");

	// A pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_tvalid || m_tready))
		else $error("output register overwritten");

	// The divider is launched only right after an event is captured
	a_div_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> $past(cmd.accept))
		else $error("divider started out of sequence");

endmodule

### rtl/core/vplfc_div.sv
// ----------------------------------------------------------------------------
// vplfc_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module vplfc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [vplfc_pkg::DIVD_W-1:0] dividend,
	input  logic [vplfc_pkg::DIVR_W-1:0] divisor,
	output logic [vplfc_pkg::DIVD_W-1:0] quotient,
	output logic [vplfc_pkg::DIVR_W-1:0] remainder,
	output logic                          done
);
	import vplfc_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic [DIVD_W-1:0]   quo_q;
	logic [DIVR_W-1:0]   rem_q;
	logic [DIVR_W-1:0]   dvs_q;
	logic [DIVR_W:0]     trial;
	logic [DIVR_W:0]     diff;
	logic                take;

	// Trial subtract of the shifted partial remainder
	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign take  = (trial >= {1'b0, dvs_q});

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DCNT_W'(1);
				if (cnt_q == DCNT_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient shifter
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], take};
			rem_q <= take ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

### rtl/core/vplfc_dp.sv
// ----------------------------------------------------------------------------
// vplfc_dp
// Datapath: configuration, stabilizer and animation clock state, event
// evaluation, shared divider and output register.
// ----------------------------------------------------------------------------
module vplfc_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  vplfc_pkg::vplfc_cmd_t             cmd,
	output vplfc_pkg::vplfc_sts_t             sts,
	input  logic [vplfc_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [vplfc_pkg::FUNC_W-1:0]      s_tuser,
	input  logic                              cfg_valid,
	input  logic [vplfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vplfc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [vplfc_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import vplfc_pkg::*;

	// Configuration
	logic [BOUND_W-1:0] lower_q;
	logic [BOUND_W-1:0] upper_q;
	logic [REQ_W-1:0]   req_q;

	// Latched event
	vplfc_func_t        func_q;
	logic [TIME_W-1:0]  now_q;

	// Clock state
	logic               listening_q;
	logic               running_q;
	logic [TIME_W-1:0]  stab_start_q;
	logic [TIME_W-1:0]  last_swap_q;
	logic [CNT_W-1:0]   run_count_q;
	logic [PER_W-1:0]   period_q;
	logic [TIME_W-1:0]  anim_start_q;
	logic [ANIM_W-1:0]  anim_time_q;
	logic               found_q;

	// Output register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// Evaluation
	logic [TIME_W-1:0]  current;
	logic [TIME_W-1:0]  delta;
	logic               in_bounds;
	logic [CNT_W-1:0]   run_inc;
	logic               latch;
	logic [TIME_W-1:0]  wall_diff;
	logic [ANIM_W-1:0]  wall;
	logic [ANIM_W:0]    step_sum;
	logic [ANIM_W-1:0]  step_sat;
	logic [ANIM_W+1:0]  lag_sum;
	logic               has_period;
	logic               snap;
	logic [ANIM_W-1:0]  snap_val;
	logic [ANIM_W-1:0]  reported;

	// Divider
	logic [DIVD_W-1:0]  div_dividend;
	logic [DIVR_W-1:0]  div_divisor;
	logic [DIVD_W-1:0]  div_quo;
	logic [DIVR_W-1:0]  div_rem;
	logic               div_done;
	logic [PER_W-1:0]   quo_sat;

	// Register writes; index 3 is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= LOWER_RST;
			upper_q <= UPPER_RST;
			req_q   <= REQ_RST;
		end else if (cfg_valid) begin
			case (vplfc_reg_t'(cfg_index))
				REG_LOWER_BOUND: lower_q <= cfg_data[BOUND_W-1:0];
				REG_UPPER_BOUND: upper_q <= cfg_data[BOUND_W-1:0];
				REG_REQ_COUNT:   req_q   <= cfg_data[REQ_W-1:0];
				default: ;
			endcase
		end
	end

	// Input capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= vplfc_func_t'(s_tuser);
			now_q  <= s_tdata[TIME_W-1:0];
		end
	end

	// Swap interval check
	assign current   = now_q - stab_start_q;
	assign delta     = current - last_swap_q;
	assign in_bounds = (delta >= TIME_W'(lower_q)) && (delta <= TIME_W'(upper_q));
	assign run_inc   = run_count_q + CNT_W'(1);
	assign latch     = listening_q && in_bounds && (run_inc > CNT_W'(req_q));

	// Wall time since the last start, fixed point
	assign wall_diff = now_q - anim_start_q;
	assign wall      = ANIM_W'({wall_diff, {FRAC_W{1'b0}}});

	// Animation step with saturation
	assign has_period = (period_q != '0);
	assign step_sum   = {1'b0, anim_time_q} + (ANIM_W + 1)'(period_q);
	assign step_sat   = step_sum[ANIM_W] ? {ANIM_W{1'b1}} : step_sum[ANIM_W-1:0];

	// Lag test: stepped time plus one period behind wall time. A saturated
	// step can never lag, so the unsaturated sum gives the same answer.
	assign lag_sum  = {2'b0, anim_time_q} + (ANIM_W + 2)'({period_q, 1'b0});
	assign snap     = has_period && (lag_sum < {2'b0, wall});

	// Next period multiple above wall time: wall - (wall mod p) + p
	assign snap_val = wall - ANIM_W'(div_rem) + ANIM_W'(period_q);

	// Divider operands
	always_comb begin
		if (func_q == FUNC_SWAP) begin
			div_dividend = {current, {FRAC_W{1'b0}}};
			div_divisor  = DIVR_W'(run_inc);
		end else begin
			div_dividend = wall[DIVD_W-1:0];
			div_divisor  = period_q;
		end
	end

	vplfc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_quo),
		.remainder (div_rem),
		.done      (div_done)
	);

	assign quo_sat = (div_quo[DIVD_W-1:PER_W] != '0) ? {PER_W{1'b1}} : div_quo[PER_W-1:0];

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listening_q  <= 1'b0;
			running_q    <= 1'b0;
			stab_start_q <= '0;
			last_swap_q  <= '0;
			run_count_q  <= '0;
			period_q     <= '0;
			anim_start_q <= '0;
			anim_time_q  <= '0;
			found_q      <= 1'b0;
		end else if (cmd.commit) begin
			found_q <= 1'b0;
			case (func_q)
				FUNC_SWAP: begin
					if (listening_q) begin
						if (!in_bounds) begin
							run_count_q  <= '0;
							stab_start_q <= now_q;
							last_swap_q  <= '0;
						end else if (latch) begin
							period_q     <= quo_sat;
							found_q      <= 1'b1;
							run_count_q  <= '0;
							stab_start_q <= now_q;
							last_swap_q  <= '0;
						end else begin
							run_count_q <= run_inc;
							last_swap_q <= current;
						end
					end
				end
				FUNC_ADVANCE: begin
					if (!has_period) begin
						anim_time_q <= wall;
					end else if (snap) begin
						anim_time_q <= snap_val;
					end else begin
						anim_time_q <= step_sat;
					end
				end
				FUNC_START: begin
					if (!listening_q) begin
						listening_q  <= 1'b1;
						run_count_q  <= '0;
						stab_start_q <= now_q;
						last_swap_q  <= '0;
					end
					running_q    <= 1'b1;
					anim_time_q  <= '0;
					anim_start_q <= now_q;
				end
				default: ;
			endcase
		end
	end

	// Elapsed query, taken after the state update
	assign reported = (!running_q || !has_period) ? wall : anim_time_q;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= OUT_DATA_W'({reported, anim_time_q, period_q, found_q});
		end
	end

	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_data_q;

	assign sts.need_div = ((func_q == FUNC_SWAP) && latch) ||
	                      ((func_q == FUNC_ADVANCE) && snap);
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || m_tready;

endmodule

### rtl/core/vplfc_ctrl.sv
// ----------------------------------------------------------------------------
// vplfc_ctrl
// Event sequencer: capture, evaluate, optional divide, deliver.
// ----------------------------------------------------------------------------
module vplfc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  vplfc_pkg::vplfc_sts_t sts,
	output vplfc_pkg::vplfc_cmd_t cmd
);
	import vplfc_pkg::*;

	vplfc_state_t state_q;
	vplfc_state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_nxt = ST_EVAL;
			ST_EVAL: state_nxt = sts.need_div ? ST_DIV : ST_OUT;
			ST_DIV:  if (sts.div_done) state_nxt = ST_OUT;
			ST_OUT:  if (sts.out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		s_tready      = 1'b0;
		cmd           = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			ST_EVAL: begin
				cmd.div_start = sts.need_div;
				cmd.commit    = !sts.need_div;
			end
			ST_DIV: begin
				cmd.commit = sts.div_done;
			end
			ST_OUT: begin
				cmd.load_out = sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

### tb/tb_vsync_period_lock_frame_clock.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vsync_period_lock_frame_clock
// Self-checking bench for the vsync period lock frame clock.
// ----------------------------------------------------------------------------
// A clock tracker mirrors the stabilizer, the locked period and the animation
// clock, and queues one predicted result per accepted event. Each result
// transfer is compared field by field with the oldest prediction.
// Stimulus is a short directed pass (wrap-around, bound edges, repeated start,
// advance before start), a lock run at the reset settings, then random swap
// trains with advances, starts and noise under several bound and count
// settings. Both stream sides idle at random. One phase holds off the result
// side for a long stretch while events keep coming in.
// ----------------------------------------------------------------------------

class frame_clock_tracker;

	typedef struct {
		bit        found;
		bit [23:0] period;
		bit [47:0] anim;
		bit [47:0] reported;
	} frame_result_t;

	// Register copies
	bit [9:0]  lower_ms;
	bit [9:0]  upper_ms;
	bit [15:0] req_count;

	// Clock state
	bit        listening;
	bit        running;
	bit [31:0] stab_start;
	bit [31:0] last_swap;
	bit [16:0] run_count;
	bit [23:0] period;
	bit [31:0] anim_start;
	bit [47:0] anim_time;

	frame_result_t pending_results[$];
	int            mismatch_count;

	function new();
		lower_ms       = vplfc_pkg::LOWER_RST;
		upper_ms       = vplfc_pkg::UPPER_RST;
		req_count      = vplfc_pkg::REQ_RST;
		listening      = 1'b0;
		running        = 1'b0;
		stab_start     = '0;
		last_swap      = '0;
		run_count      = '0;
		period         = '0;
		anim_start     = '0;
		anim_time      = '0;
		mismatch_count = 0;
	endfunction

	function void set_reg(vplfc_pkg::vplfc_reg_t idx, bit [15:0] value);
		case (idx)
			vplfc_pkg::REG_LOWER_BOUND: lower_ms  = value[9:0];
			vplfc_pkg::REG_UPPER_BOUND: upper_ms  = value[9:0];
			vplfc_pkg::REG_REQ_COUNT:   req_count = value;
			default: ;
		endcase
	endfunction

	function void restart_stabilizer(bit [31:0] now);
		run_count  = '0;
		stab_start = now;
		last_swap  = '0;
	endfunction

	// Wall time since the last start, scaled to 8 fraction bits
	function bit [63:0] wall_fixed(bit [31:0] now);
		bit [31:0] elapsed;
		elapsed = now - anim_start;
		return {24'd0, elapsed, 8'd0};
	endfunction

	function int pending();
		return pending_results.size();
	endfunction

	// Apply one accepted event and queue the result it must give
	function void note_event(vplfc_pkg::vplfc_func_t func, bit [31:0] now);
		frame_result_t r;
		bit [31:0]     current;
		bit [31:0]     delta;
		bit [63:0]     quot;
		bit [63:0]     wall;
		bit [63:0]     step;
		r.found = 1'b0;
		case (func)
			vplfc_pkg::FUNC_SWAP: begin
				if (listening) begin
					current = now - stab_start;
					delta   = current - last_swap;
					if (delta < lower_ms || delta > upper_ms) begin
						restart_stabilizer(now);
					end else begin
						run_count++;
						if (run_count > req_count) begin
							quot    = {24'd0, current, 8'd0} / run_count;
							period  = (quot > 64'hFF_FFFF) ? 24'hFF_FFFF : quot[23:0];
							r.found = 1'b1;
							restart_stabilizer(now);
						end else begin
							last_swap = current;
						end
					end
				end
			end
			vplfc_pkg::FUNC_ADVANCE: begin
				wall = wall_fixed(now);
				if (period != 0) begin
					step = anim_time + period;
					if (step > 64'hFFFF_FFFF_FFFF)
						step = 64'hFFFF_FFFF_FFFF;
					// lagging more than a period: snap to the next multiple
					if (step + period < wall)
						step = (wall / period + 1) * period;
					anim_time = step[47:0];
				end else begin
					anim_time = wall[47:0];
				end
			end
			vplfc_pkg::FUNC_START: begin
				if (!listening) begin
					listening = 1'b1;
					restart_stabilizer(now);
				end
				running    = 1'b1;
				anim_time  = '0;
				anim_start = now;
			end
			default: ;
		endcase
		wall       = wall_fixed(now);
		r.period   = period;
		r.anim     = anim_time;
		r.reported = (!running || period == 0) ? wall[47:0] : anim_time;
		pending_results.push_back(r);
	endfunction

	function void compare_field(string field, bit [47:0] want, logic [47:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatch_count++;
		end
	endfunction

	// Check one result transfer against the oldest prediction
	function void check_result(logic [vplfc_pkg::OUT_DATA_W-1:0] data);
		frame_result_t want;
		if (pending_results.size() == 0) begin
			$error("result transfer with no event pending: tdata %h", data);
			mismatch_count++;
			return;
		end
		want = pending_results.pop_front();
		compare_field("period_found", 48'(want.found), 48'(data[0]));
		compare_field("stable_period", 48'(want.period), 48'(data[24:1]));
		compare_field("animation_time", want.anim, data[72:25]);
		compare_field("reported_time", want.reported, data[120:73]);
	endfunction

endclass

module tb_vsync_period_lock_frame_clock;

	localparam int HOLD_CYCLES  = 400;   // long result-side hold-off
	localparam int DRAIN_CYCLES = 50;    // long enough to cover the divide path

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [vplfc_pkg::IN_DATA_W-1:0]     s_tdata;
	logic [vplfc_pkg::FUNC_W-1:0]        s_tuser;
	logic                                m_tvalid;
	logic                                m_tready;
	logic [vplfc_pkg::OUT_DATA_W-1:0]    m_tdata;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [vplfc_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [vplfc_pkg::CFG_DATA_W-1:0]    cfg_data;

	frame_clock_tracker tracker;
	bit                 idle_on;
	bit                 hold_off_req;
	logic [31:0]        clock_ms;
	int                 cur_lo;
	int                 cur_hi;

	vsync_period_lock_frame_clock u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Event transfers feed the tracker
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			tracker.note_event(vplfc_pkg::vplfc_func_t'(s_tuser), s_tdata);
	end

	// Result transfers are checked
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata);
	end

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		int wait_cycles;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			wait_cycles = idle_on ? $urandom_range(0, 6) : 0;
			if (hold_off_req) begin
				wait_cycles += HOLD_CYCLES;
				hold_off_req = 1'b0;
			end
			if (wait_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// Offer one event; returns at the falling edge after its transfer
	task automatic send_event(vplfc_pkg::vplfc_func_t func, logic [31:0] now);
		int gap;
		gap = idle_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= now;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic swap_after(int dt);
		clock_ms = clock_ms + dt;
		send_event(vplfc_pkg::FUNC_SWAP, clock_ms);
	endtask

	// Stop sending and let every outstanding result come back
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Leaves cfg_valid high so back-to-back writes follow without a gap
	task automatic write_reg(vplfc_pkg::vplfc_reg_t idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(idx, value);
		@(negedge clk);
	endtask

	// Bound writes carry junk in the unused upper data bits
	task automatic configure(int lo, int hi, int req);
		logic [15:0] junk;
		junk = 16'($urandom);
		write_reg(vplfc_pkg::REG_LOWER_BOUND, {junk[15:10], lo[9:0]});
		write_reg(vplfc_pkg::REG_UPPER_BOUND, {junk[9:4], hi[9:0]});
		write_reg(vplfc_pkg::REG_REQ_COUNT, req[15:0]);
		cfg_valid <= 1'b0;
		cur_lo = lo;
		cur_hi = hi;
	endtask

	// Mostly in-bound swap trains, with advances, starts, breaks and noise
	task automatic random_phase(int count);
		int          pick;
		int          dt;
		logic [31:0] junk;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				if (cur_lo <= cur_hi)
					dt = $urandom_range(cur_lo, cur_hi);
				else
					dt = $urandom_range(0, 1100);
				swap_after(dt);
			end else if (pick < 68) begin
				case ($urandom_range(0, 2))
					0: dt = (cur_lo > 0) ? $urandom_range(0, cur_lo - 1) : cur_hi + 1;
					1: dt = cur_hi + $urandom_range(1, 2000);
					default: dt = -int'($urandom_range(1, 100));
				endcase
				swap_after(dt);
			end else if (pick < 86) begin
				// an occasional far jump makes the animation clock snap forward
				if ($urandom_range(0, 9) == 0)
					dt = $urandom_range(0, 20000);
				else
					dt = $urandom_range(0, 40);
				send_event(vplfc_pkg::FUNC_ADVANCE, clock_ms + dt);
			end else if (pick < 90) begin
				clock_ms = clock_ms + $urandom_range(0, 50);
				send_event(vplfc_pkg::FUNC_START, clock_ms);
			end else if (pick < 94) begin
				send_event(vplfc_pkg::FUNC_NONE, $urandom);
			end else begin
				junk = $urandom;
				send_event(vplfc_pkg::vplfc_func_t'($urandom_range(0, 3)), junk);
			end
		end
	endtask

	// Run limit
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int lo;
		int hi;
		tracker      = new();
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = vplfc_pkg::FUNC_NONE;
		cfg_valid    = 1'b0;
		cfg_index    = vplfc_pkg::REG_LOWER_BOUND;
		cfg_data     = '0;
		idle_on      = 1'b1;
		hold_off_req = 1'b0;
		clock_ms     = '0;
		cur_lo       = vplfc_pkg::LOWER_RST;
		cur_hi       = vplfc_pkg::UPPER_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: idle code, swap and advance before any start
		send_event(vplfc_pkg::FUNC_NONE, 32'd0);
		send_event(vplfc_pkg::FUNC_SWAP, 32'd123);
		send_event(vplfc_pkg::FUNC_ADVANCE, 32'hFFFF_FFFF);
		// Start near the top of the counter; the swap train crosses the wrap
		clock_ms = 32'hFFFF_FFC0;
		send_event(vplfc_pkg::FUNC_START, clock_ms);
		repeat (5) swap_after(16);
		// Below, above, then exactly on each bound, then a backward step
		swap_after(14);
		swap_after(19);
		swap_after(15);
		swap_after(18);
		swap_after(-5);
		send_event(vplfc_pkg::FUNC_START, clock_ms + 3);
		send_event(vplfc_pkg::FUNC_ADVANCE, clock_ms + 40);
		send_event(vplfc_pkg::FUNC_NONE, 32'hFFFF_FFFF);

		// Lock at the reset settings, then lag far enough to snap forward
		for (int i = 0; i < 130; i++) begin
			if (i % 5 == 4)
				send_event(vplfc_pkg::FUNC_ADVANCE, clock_ms + $urandom_range(0, 16));
			else
				swap_after($urandom_range(15, 18));
		end
		send_event(vplfc_pkg::FUNC_ADVANCE, clock_ms + 5000);
		send_event(vplfc_pkg::FUNC_ADVANCE, clock_ms + 5016);
		wait_drain();

		// Short count, with a sender pause halfway
		configure(15, 18, 3);
		random_phase(60);
		wait_drain();
		random_phase(60);
		wait_drain();

		// Widest bounds, lock on the first in-bound swap, no idling
		idle_on = 1'b0;
		write_reg(vplfc_pkg::REG_UNUSED, 16'($urandom));
		configure(0, 1023, 0);
		random_phase(80);
		wait_drain();

		idle_on = 1'b1;
		configure(1023, 1023, 1);
		random_phase(40);
		wait_drain();

		// Crossed bounds: nothing is ever in bound
		configure(20, 10, 2);
		random_phase(40);
		wait_drain();

		configure(0, 0, 2);
		random_phase(40);
		wait_drain();

		configure(16, 17, 65535);
		random_phase(60);
		wait_drain();

		// Result side holds off while events keep coming; time wraps again
		configure(15, 18, 2);
		clock_ms     = 32'hFFFF_FC00;
		idle_on      = 1'b0;
		hold_off_req = 1'b1;
		random_phase(150);
		wait_drain();

		idle_on = 1'b1;
		for (int k = 0; k < 3; k++) begin
			lo = $urandom_range(0, 40);
			hi = lo + $urandom_range(0, 12);
			configure(lo, hi, $urandom_range(0, 6));
			random_phase(60);
			wait_drain();
		end

		if (tracker.mismatch_count == 0 && tracker.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### sim.f
rtl/core/vplfc_pkg.sv
rtl/core/vplfc_div.sv
rtl/core/vplfc_dp.sv
rtl/core/vplfc_ctrl.sv
rtl/core/vsync_period_lock_frame_clock.sv
tb/tb_vsync_period_lock_frame_clock.sv
